// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/vmap_pkg.sv
package vmap_pkg;

    // item opcodes
    localparam logic [1:0] OP_ATTEMPT  = 2'd0;
    localparam logic [1:0] OP_SET_ADDR = 2'd1;
    localparam logic [1:0] OP_SET_CTRL = 2'd2;
    localparam logic [1:0] OP_SET_DATA = 2'd3;

    // access kinds
    localparam logic [1:0] KIND_NONE       = 2'd0;
    localparam logic [1:0] KIND_READ       = 2'd1;
    localparam logic [1:0] KIND_WRITE_DATA = 2'd2;
    localparam logic [1:0] KIND_WRITE_BYTE = 2'd3;

    // address step modes
    localparam logic [1:0] STEP_HOLD   = 2'd0;
    localparam logic [1:0] STEP_PLUS1  = 2'd1;
    localparam logic [1:0] STEP_PLUS128 = 2'd2;
    localparam logic [1:0] STEP_ALT    = 2'd3;

    // config port
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_LINES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCESSES      = 4'd1;

    localparam logic [9:0] DISPLAY_LINES_RESET = 10'd192;
    localparam logic [7:0] ACCESSES_RESET      = 8'd8;

    typedef struct packed {
        logic        we;
        logic        re;
        logic        dev;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;

    function automatic logic [15:0] step_addr(input logic [15:0] a, input logic [1:0] mode);
        logic [15:0] s;
        begin
            case (mode)
                STEP_PLUS1:   s = a + 16'd1;
                STEP_PLUS128: s = a + 16'd128;
                STEP_ALT:     s = a + (a[0] ? 16'd127 : 16'd1);
                default:      s = a;
            endcase
            return s;
        end
    endfunction

endpackage

// File: src/vmap_bank.sv
module vmap_bank #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [7:0]           i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [7:0]           o_rdata
);

    logic [7:0] r_mem [2**ADDR_BITS];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// File: src/vmap_store.sv
module vmap_store #(
    parameter int DEVICE_COUNT = 2,
    parameter int ADDR_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vmap_pkg::t_mem_req  i_req,
    output logic                o_busy,
    output logic [7:0]          o_rdata
);
    import vmap_pkg::*;

    logic [ADDR_BITS-1:0] r_clr_addr, n_clr_addr;
    logic                 r_busy, n_busy;
    logic                 r_rd_dev, n_rd_dev;
    logic [7:0]           w_q [DEVICE_COUNT];

    // clear sweep: all banks in parallel, one row per cycle
    always_comb begin
        n_clr_addr = r_clr_addr;
        n_busy     = r_busy;
        n_rd_dev   = r_rd_dev;
        if (r_busy) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                n_busy = 1'b0;
            end
        end
        if (i_req.re) begin
            n_rd_dev = i_req.dev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_busy     <= 1'b1;
            r_rd_dev   <= 1'b0;
        end else begin
            r_clr_addr <= n_clr_addr;
            r_busy     <= n_busy;
            r_rd_dev   <= n_rd_dev;
        end
    end

    for (genvar g = 0; g < DEVICE_COUNT; g++) begin : g_bank
        logic w_sel;
        assign w_sel = (32'(i_req.dev) == g);

        vmap_bank #(
            .ADDR_BITS(ADDR_BITS)
        ) u_bank (
            .i_clk  (i_clk),
            .i_we   (r_busy || (i_req.we && w_sel)),
            .i_waddr(r_busy ? r_clr_addr : i_req.addr[ADDR_BITS-1:0]),
            .i_wdata(r_busy ? 8'd0 : i_req.wdata),
            .i_re   (!r_busy && i_req.re && w_sel),
            .i_raddr(i_req.addr[ADDR_BITS-1:0]),
            .o_rdata(w_q[g])
        );
    end

    always_comb begin
        o_rdata = 8'd0;
        for (int k = 0; k < DEVICE_COUNT; k++) begin
            if (32'(r_rd_dev) == k) begin
                o_rdata = o_rdata | w_q[k];
            end
        end
    end

    assign o_busy = r_busy;

endmodule

// File: src/video_memory_access_port_core.sv
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+------------------------------------
// in       | host->core| i_in_valid / o_in_stall      | opcode, line, address, control, byte
// out      | core->host| o_out_valid / i_out_stall    | access_done, data, address, budget
// cfg      | host->core| i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One item per cycle while in is not stalled: the accept edge updates all state and
// launches at most one bank access; the result is valid in the next cycle and another
// item can enter then. A memory read lands in the bank read register at the same edge
// that registers the result, and is muxed straight onto o_data_out with no extra register.
// After reset the banks are cleared one row at a time across all 2**ADDR_BITS rows (all
// banks at once); input stays stalled until then. Config writes are always taken.
// An out stall while a result is valid holds the result and stalls in in that same cycle.
`include "assert_macros.svh"

module video_memory_access_port_core #(
    parameter int DEVICE_COUNT = 2,
    parameter int ADDR_BITS    = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // in
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_opcode,
    input  logic [9:0]                         i_line_number,
    input  logic [15:0]                        i_new_address,
    input  logic                               i_device_select,
    input  logic [1:0]                         i_access_kind,
    input  logic [1:0]                         i_step_mode,
    input  logic [7:0]                         i_byte_value,
    // out
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_access_done,
    output logic [7:0]                         o_data_out,
    output logic [15:0]                        o_address_out,
    output logic [7:0]                         o_budget_left,
    // cfg
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vmap_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vmap_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import vmap_pkg::*;

    // architectural state
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_data, n_data;
    logic        r_rd_pend, n_rd_pend;   // data register lives in the bank read register
    logic        r_dev, n_dev;
    logic [1:0]  r_kind, n_kind;
    logic [1:0]  r_step, n_step;
    logic [9:0]  r_last_line, n_last_line;
    logic [7:0]  r_budget, n_budget;
    logic [9:0]  r_disp_lines, n_disp_lines;
    logic [7:0]  r_apl, n_apl;
    // result slot
    logic        r_out_valid, n_out_valid;
    logic        r_out_done, n_out_done;

    logic        w_accept;
    logic        w_busy;
    logic [7:0]  w_rdata;
    logic [7:0]  w_data_cur;
    logic        w_new_line;
    logic [7:0]  w_bud_rl;
    logic        w_display;
    logic        w_refuse;
    logic        w_dev_ok;
    t_mem_req    w_req;

    assign o_in_stall = w_busy || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    // current data register: a read issued by the last item is still in the bank register
    assign w_data_cur = r_rd_pend ? w_rdata : r_data;

    // budget reload happens before the refusal check
    assign w_new_line = (i_line_number != r_last_line);
    assign w_bud_rl   = w_new_line ? r_apl : r_budget;
    assign w_display  = (i_line_number < r_disp_lines);
    assign w_refuse   = w_display && (w_bud_rl == 8'd0);
    assign w_dev_ok   = (32'(r_dev) < DEVICE_COUNT);

    always_comb begin
        n_addr       = r_addr;
        n_data       = r_data;
        n_rd_pend    = r_rd_pend;
        n_dev        = r_dev;
        n_kind       = r_kind;
        n_step       = r_step;
        n_last_line  = r_last_line;
        n_budget     = r_budget;
        n_disp_lines = r_disp_lines;
        n_apl        = r_apl;
        n_out_valid  = r_out_valid;
        n_out_done   = r_out_done;

        w_req        = '0;
        w_req.dev    = r_dev;
        w_req.addr   = r_addr;
        w_req.wdata  = w_data_cur;

        if (w_accept) begin
            n_out_valid = 1'b1;
            n_out_done  = 1'b0;
            n_data      = w_data_cur;
            n_rd_pend   = 1'b0;
            unique case (i_opcode)
                OP_ATTEMPT: begin
                    n_last_line = i_line_number;
                    n_budget    = w_bud_rl;
                    if (!w_refuse) begin
                        if (w_display) begin
                            n_budget = w_bud_rl - 8'd1;
                        end
                        n_out_done = 1'b1;
                        n_addr     = step_addr(r_addr, r_step);
                        case (r_kind)
                            KIND_READ: begin
                                if (w_dev_ok) begin
                                    w_req.re  = 1'b1;
                                    n_rd_pend = 1'b1;
                                end else begin
                                    n_data = 8'd0;
                                end
                            end
                            KIND_WRITE_DATA: begin
                                w_req.we = w_dev_ok;
                            end
                            KIND_WRITE_BYTE: begin
                                w_req.we    = w_dev_ok;
                                w_req.wdata = i_byte_value;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                OP_SET_ADDR: begin
                    n_addr = i_new_address;
                end
                OP_SET_CTRL: begin
                    n_dev  = i_device_select;
                    n_kind = i_access_kind;
                    n_step = i_step_mode;
                end
                OP_SET_DATA: begin
                    n_data = i_byte_value;
                end
                default: begin
                end
            endcase
        end else if (r_out_valid && !i_out_stall) begin
            // result leaves: fold any read data back into the data register
            n_out_valid = 1'b0;
            n_data      = w_data_cur;
            n_rd_pend   = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DISPLAY_LINES: n_disp_lines = i_cfg_data;
                CFG_ACCESSES:      n_apl        = i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_data       <= '0;
            r_rd_pend    <= 1'b0;
            r_dev        <= 1'b0;
            r_kind       <= KIND_NONE;
            r_step       <= STEP_HOLD;
            r_last_line  <= '0;
            r_budget     <= '0;
            r_disp_lines <= DISPLAY_LINES_RESET;
            r_apl        <= ACCESSES_RESET;
            r_out_valid  <= 1'b0;
            r_out_done   <= 1'b0;
        end else begin
            r_addr       <= n_addr;
            r_data       <= n_data;
            r_rd_pend    <= n_rd_pend;
            r_dev        <= n_dev;
            r_kind       <= n_kind;
            r_step       <= n_step;
            r_last_line  <= n_last_line;
            r_budget     <= n_budget;
            r_disp_lines <= n_disp_lines;
            r_apl        <= n_apl;
            r_out_valid  <= n_out_valid;
            r_out_done   <= n_out_done;
        end
    end

    vmap_store #(
        .DEVICE_COUNT(DEVICE_COUNT),
        .ADDR_BITS   (ADDR_BITS)
    ) u_store (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_busy (w_busy),
        .o_rdata(w_rdata)
    );

    // result fields are the state after the item in the slot
    assign o_out_valid   = r_out_valid;
    assign o_access_done = r_out_done;
    assign o_data_out    = w_data_cur;
    assign o_address_out = r_addr;
    assign o_budget_left = r_budget;
    assign o_cfg_ready   = 1'b1;

    `ASSERT_NEXT(a_refuse_holds, i_clk, i_rst_n,
        w_accept && (i_opcode == OP_ATTEMPT) && w_refuse,
        !o_access_done && $stable(r_addr), "refused attempt changed address or reported done")
    `ASSERT_NEXT(a_done_only_attempt, i_clk, i_rst_n,
        w_accept && (i_opcode != OP_ATTEMPT),
        !o_access_done, "done flagged for non-attempt item")
    `ASSERT_IMPL(a_pend_has_result, i_clk, i_rst_n,
        r_rd_pend, r_out_valid, "read pending without a result item")
    `ASSERT_IMPL(a_clear_idle, i_clk, i_rst_n,
        w_busy, !r_out_valid && !r_rd_pend, "activity during clear sweep")
    `ASSERT_NEXT(a_budget_spend, i_clk, i_rst_n,
        w_accept && (i_opcode == OP_ATTEMPT) && !w_new_line && w_display && (r_budget != 8'd0),
        r_budget == 8'($past(r_budget) - 8'd1), "budget not spent by one")

endmodule
